// ===== src/gprsns_pkg.sv =====
// Shared types, codes and reply tables of the GPRS network-service PDU handler.
`default_nettype none

package gprsns_pkg;

	// PDU type codes.
	localparam logic [7:0] T_UNITDATA    = 8'h00;
	localparam logic [7:0] T_RESET       = 8'h02;
	localparam logic [7:0] T_RESET_ACK   = 8'h03;
	localparam logic [7:0] T_UNBLOCK     = 8'h06;
	localparam logic [7:0] T_UNBLOCK_ACK = 8'h07;
	localparam logic [7:0] T_ALIVE       = 8'h0A;
	localparam logic [7:0] T_ALIVE_ACK   = 8'h0B;

	// Information element tags and the identifier length.
	localparam logic [7:0] TAG_CIRCUIT = 8'h01;
	localparam logic [7:0] TAG_ENTITY  = 8'h02;
	localparam logic [7:0] TAG_SDU     = 8'h04;
	localparam logic [7:0] ID_LEN      = 8'h02;

	// Configuration register indexes.
	localparam logic CFG_ENTITY_ID  = 1'b0;
	localparam logic CFG_CIRCUIT_ID = 1'b1;

	// Result sequence positions: payload, reply bytes one through nine, status.
	localparam logic [3:0] STEP_PAYLOAD = 4'd0;
	localparam logic [3:0] STEP_REPLY0  = 4'd1;
	localparam logic [3:0] STEP_STATUS  = 4'd10;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_REPLY   = 2'd1,
		KIND_STATUS  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		OUT_NO_REPLY = 3'd0,
		OUT_REPLIED  = 3'd1,
		OUT_SDU_OK   = 3'd2,
		OUT_SDU_BAD  = 3'd3,
		OUT_UNKNOWN  = 3'd4
	} outcome_t;

	typedef enum logic [2:0] {
		REPLY_NONE        = 3'd0,
		REPLY_RESET_ACK   = 3'd1,
		REPLY_UNBLOCK     = 3'd2,
		REPLY_UNBLOCK_ACK = 3'd3,
		REPLY_ALIVE_ACK   = 3'd4
	} reply_t;

	typedef enum logic [4:0] {
		PH_TYPE   = 5'b00001,
		PH_TAG    = 5'b00010,
		PH_LEN    = 5'b00100,
		PH_VALUE  = 5'b01000,
		PH_IGNORE = 5'b10000
	} phase_t;

	// Everything the result side needs to replay the results of one item.
	// Counters are the values before the PDU end; the inc flags give the update.
	typedef struct packed {
		logic        has_payload;
		logic [7:0]  payload;
		reply_t      reply_sel;
		logic        has_status;
		outcome_t    outcome;
		logic        pre_alive;
		logic        post_alive;
		logic [31:0] rx_frames;
		logic [31:0] tx_frames;
		logic [31:0] rx_alives;
		logic [31:0] tx_alives;
		logic        inc_rx_frame;
		logic        inc_tx_frame;
		logic        inc_rx_alive;
		logic        inc_tx_alive;
	} job_t;

	function automatic logic [3:0] reply_len(input reply_t sel);
		logic [3:0] len;
		unique case (sel)
			REPLY_RESET_ACK:   len = 4'd9;
			REPLY_UNBLOCK:     len = 4'd1;
			REPLY_UNBLOCK_ACK: len = 4'd1;
			REPLY_ALIVE_ACK:   len = 4'd1;
			default:           len = 4'd0;
		endcase
		return len;
	endfunction

	// Byte at position pos (one-based) of the reply selected by sel.
	function automatic logic [7:0] reply_byte(input reply_t sel, input logic [3:0] pos,
			input logic [15:0] entity_id, input logic [15:0] circuit_id);
		logic [7:0] b;
		b = 8'h00;
		unique case (sel)
			REPLY_RESET_ACK: begin
				unique case (pos)
					4'd1:    b = T_RESET_ACK;
					4'd2:    b = TAG_CIRCUIT;
					4'd3:    b = ID_LEN;
					4'd4:    b = circuit_id[15:8];
					4'd5:    b = circuit_id[7:0];
					4'd6:    b = TAG_ENTITY;
					4'd7:    b = ID_LEN;
					4'd8:    b = entity_id[15:8];
					4'd9:    b = entity_id[7:0];
					default: b = 8'h00;
				endcase
			end
			REPLY_UNBLOCK:     b = T_UNBLOCK;
			REPLY_UNBLOCK_ACK: b = T_UNBLOCK_ACK;
			REPLY_ALIVE_ACK:   b = T_ALIVE_ACK;
			default:           b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== src/gprsns_parser.sv =====
// PDU parser: element walk, connection state, counters and the per-item result job.
`default_nettype none

module gprsns_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                proc_en,
	input  logic                mode,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output gprsns_pkg::job_t    job,
	output logic                job_any
);
	import gprsns_pkg::*;

	phase_t      phase_q, phase_n;
	logic [7:0]  kind_q, kind_n;
	logic [7:0]  left_q, left_n;
	logic [7:0]  left_dec;
	logic        match_q, match_n;
	logic        sdu_done_q, sdu_done_n;
	logic        alive_q, alive_n;
	logic [31:0] rx_frames_q, tx_frames_q, rx_alives_q, tx_alives_q;

	assign left_dec = left_q - 8'd1;

	always_comb begin
		phase_n    = phase_q;
		kind_n     = kind_q;
		left_n     = left_q;
		match_n    = match_q;
		sdu_done_n = sdu_done_q;
		alive_n    = alive_q;

		job.has_payload  = 1'b0;
		job.payload      = data_byte;
		job.reply_sel    = REPLY_NONE;
		job.has_status   = 1'b0;
		job.outcome      = OUT_NO_REPLY;
		job.pre_alive    = alive_q;
		job.rx_frames    = rx_frames_q;
		job.tx_frames    = tx_frames_q;
		job.rx_alives    = rx_alives_q;
		job.tx_alives    = tx_alives_q;
		job.inc_rx_frame = 1'b0;
		job.inc_tx_frame = 1'b0;
		job.inc_rx_alive = 1'b0;
		job.inc_tx_alive = 1'b0;

		if (mode) begin
			alive_n = 1'b1;
		end else begin
			if (phase_q == PH_TYPE) begin
				kind_n     = data_byte;
				phase_n    = (data_byte == T_UNITDATA) ? PH_TAG : PH_IGNORE;
				left_n     = 8'd0;
				match_n    = 1'b0;
				sdu_done_n = 1'b0;
			end else if (kind_q == T_UNITDATA) begin
				unique case (phase_q)
					PH_TAG: begin
						match_n = (data_byte == TAG_SDU);
						phase_n = PH_LEN;
					end
					PH_LEN: begin
						left_n = data_byte;
						if (match_q) begin
							if (data_byte == 8'd0) begin
								sdu_done_n = 1'b1;
								phase_n    = PH_IGNORE;
							end else begin
								phase_n = PH_VALUE;
							end
						end else begin
							phase_n = (data_byte == 8'd0) ? PH_TAG : PH_VALUE;
						end
					end
					PH_VALUE: begin
						job.has_payload = match_q;
						left_n          = left_dec;
						if (left_dec == 8'd0) begin
							if (match_q) begin
								sdu_done_n = 1'b1;
								phase_n    = PH_IGNORE;
							end else begin
								phase_n = PH_TAG;
							end
						end
					end
					default: begin
					end
				endcase
			end

			if (last_byte) begin
				job.has_status   = 1'b1;
				job.inc_rx_frame = 1'b1;
				unique case (kind_n)
					T_RESET: begin
						alive_n       = 1'b0;
						job.reply_sel = REPLY_RESET_ACK;
						job.outcome   = OUT_REPLIED;
					end
					T_RESET_ACK: begin
						alive_n       = 1'b0;
						job.reply_sel = REPLY_UNBLOCK;
						job.outcome   = OUT_REPLIED;
					end
					T_UNBLOCK: begin
						alive_n       = 1'b1;
						job.reply_sel = REPLY_UNBLOCK_ACK;
						job.outcome   = OUT_REPLIED;
					end
					T_UNBLOCK_ACK: begin
						alive_n = 1'b1;
					end
					T_ALIVE: begin
						job.inc_rx_alive = 1'b1;
						job.inc_tx_alive = 1'b1;
						job.reply_sel    = REPLY_ALIVE_ACK;
						job.outcome      = OUT_REPLIED;
					end
					T_ALIVE_ACK: begin
						job.inc_rx_alive = 1'b1;
					end
					T_UNITDATA: begin
						job.outcome = sdu_done_n ? OUT_SDU_OK : OUT_SDU_BAD;
					end
					default: begin
						job.outcome = OUT_UNKNOWN;
					end
				endcase
				job.inc_tx_frame = (job.reply_sel != REPLY_NONE);
				phase_n    = PH_TYPE;
				left_n     = 8'd0;
				match_n    = 1'b0;
				sdu_done_n = 1'b0;
			end
		end
		job.post_alive = alive_n;
	end

	assign job_any = !mode && (job.has_payload || last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TYPE;
			kind_q      <= 8'd0;
			left_q      <= 8'd0;
			match_q     <= 1'b0;
			sdu_done_q  <= 1'b0;
			alive_q     <= 1'b0;
			rx_frames_q <= 32'd0;
			tx_frames_q <= 32'd0;
			rx_alives_q <= 32'd0;
			tx_alives_q <= 32'd0;
		end else if (proc_en) begin
			phase_q     <= phase_n;
			kind_q      <= kind_n;
			left_q      <= left_n;
			match_q     <= match_n;
			sdu_done_q  <= sdu_done_n;
			alive_q     <= alive_n;
			rx_frames_q <= rx_frames_q + {31'd0, job.inc_rx_frame};
			tx_frames_q <= tx_frames_q + {31'd0, job.inc_tx_frame};
			rx_alives_q <= rx_alives_q + {31'd0, job.inc_rx_alive};
			tx_alives_q <= tx_alives_q + {31'd0, job.inc_tx_alive};
		end
	end

endmodule

`default_nettype wire

// ===== src/gprsns_emitter.sv =====
// Result register and sequencer that plays out the beats of one item's job.
`default_nettype none

module gprsns_emitter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  gprsns_pkg::job_t job_in,
	input  logic [15:0]      entity_id,
	input  logic [15:0]      circuit_id,
	output logic             take_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       result_kind,
	output logic [7:0]       result_byte,
	output logic             last_result,
	output logic [2:0]       pdu_outcome,
	output logic             link_alive,
	output logic [31:0]      rx_frame_total,
	output logic [31:0]      tx_frame_total,
	output logic [31:0]      rx_alive_total,
	output logic [31:0]      tx_alive_total
);
	import gprsns_pkg::*;

	job_t       job_q;
	logic       busy_q;
	logic [3:0] step_q;
	logic [3:0] len_q;
	logic [3:0] len_in;
	logic [3:0] start_step;
	logic [3:0] next_step;
	logic       final_beat;
	logic       fire;
	logic       is_payload;

	assign len_in = reply_len(job_in.reply_sel);
	assign len_q  = reply_len(job_q.reply_sel);

	always_comb begin
		if (job_in.has_payload) begin
			start_step = STEP_PAYLOAD;
		end else if (len_in != 4'd0) begin
			start_step = STEP_REPLY0;
		end else begin
			start_step = STEP_STATUS;
		end
	end

	always_comb begin
		if (step_q == STEP_PAYLOAD) begin
			next_step = (len_q != 4'd0) ? STEP_REPLY0 : STEP_STATUS;
		end else if (step_q < len_q) begin
			next_step = step_q + 4'd1;
		end else begin
			next_step = STEP_STATUS;
		end
	end

	// A payload beat ends the job when the item carried no PDU end.
	assign final_beat = (step_q == STEP_STATUS) ||
		(step_q == STEP_PAYLOAD && !job_q.has_status);
	assign fire       = busy_q && out_ready;
	assign take_ready = !busy_q || (out_ready && final_beat);
	assign is_payload = (step_q == STEP_PAYLOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_PAYLOAD;
		end else if (load) begin
			busy_q <= 1'b1;
			step_q <= start_step;
		end else if (fire) begin
			if (final_beat) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= next_step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job_in;
		end
	end

	always_comb begin
		out_valid = busy_q;
		if (is_payload) begin
			result_kind    = KIND_PAYLOAD;
			result_byte    = job_q.payload;
			last_result    = 1'b0;
			pdu_outcome    = OUT_NO_REPLY;
			link_alive     = job_q.pre_alive;
			rx_frame_total = job_q.rx_frames;
			tx_frame_total = job_q.tx_frames;
			rx_alive_total = job_q.rx_alives;
			tx_alive_total = job_q.tx_alives;
		end else begin
			if (step_q == STEP_STATUS) begin
				result_kind = KIND_STATUS;
				result_byte = 8'h00;
				last_result = 1'b1;
				pdu_outcome = job_q.outcome;
			end else begin
				result_kind = KIND_REPLY;
				result_byte = reply_byte(job_q.reply_sel, step_q, entity_id, circuit_id);
				last_result = 1'b0;
				pdu_outcome = OUT_NO_REPLY;
			end
			link_alive     = job_q.post_alive;
			rx_frame_total = job_q.rx_frames + {31'd0, job_q.inc_rx_frame};
			tx_frame_total = job_q.tx_frames + {31'd0, job_q.inc_tx_frame};
			rx_alive_total = job_q.rx_alives + {31'd0, job_q.inc_rx_alive};
			tx_alive_total = job_q.tx_alives + {31'd0, job_q.inc_tx_alive};
		end
	end

	// A new job is only taken when the result register is free or drains now.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> take_ready)
		else $error("job loaded over a pending result");

	// The sequence position always names a beat that exists in the job.
	a_step_valid: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q == STEP_STATUS && job_q.has_status) ||
			(step_q == STEP_PAYLOAD && job_q.has_payload) ||
			(step_q >= STEP_REPLY0 && step_q <= len_q))
		else $error("result step outside its job");

	// A beat that is not the last one of a job leaves the job in place.
	a_no_early_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !final_beat) |=> busy_q)
		else $error("job dropped before its final beat");

	// Replies are followed by a status, so reply beats never end a job.
	a_status_after_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && job_q.reply_sel != REPLY_NONE) |-> job_q.has_status)
		else $error("reply without a closing status");

endmodule

`default_nettype wire

// ===== src/gprs_ns_pdu_handler.sv =====
// Top level of the GPRS network-service PDU handler: input register, parser, result sequencer.
//
// Usage. PDU bytes enter on the input channel (in_valid/in_ready), one byte per
// beat, with last_byte on the final byte of each PDU; mode set instead forces the
// virtual connection alive and yields no result. Results leave on the output
// channel (out_valid/out_ready): forwarded SDU bytes, then at a PDU end any
// response bytes and one status beat with last_result set. Every result carries
// the connection state and the four wrapping counters.
// Path: an input beat is captured in the input register and then parsed into the
// result register, from which its first result is offered. Throughput is one input
// beat per cycle as long as each byte gives at most one result and the receiver
// takes every result; an item that gives r results holds the result register for r
// output beats (up to ten for a reset: nine reply bytes and the status), which sets
// the rate through the result sequencer. Items that give no result pass the parser
// without waiting for it.
// When the receiver stalls, the current result holds and input beats are still taken
// until one that gives a result waits in the input register, then in_ready drops.
// Reset clears the parse state, the connection (blocked), the counters and the
// identifier registers; entity_id (index 0) and circuit_id (index 1) are written
// through cfg_we, by the user only while the block is idle; the block does not enforce it.
`default_nettype none

module gprs_ns_pdu_handler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [7:0]  result_byte,
	output logic        last_result,
	output logic [2:0]  pdu_outcome,
	output logic        link_alive,
	output logic [31:0] rx_frame_total,
	output logic [31:0] tx_frame_total,
	output logic [31:0] rx_alive_total,
	output logic [31:0] tx_alive_total
);
	import gprsns_pkg::*;

	logic [15:0] entity_id_q;
	logic [15:0] circuit_id_q;

	// Input register.
	logic        v_s1;
	logic        mode_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	job_t        job;
	logic        job_any;
	logic        take_ready;
	logic        advance;

	// The held beat moves on when it produces no result or the result side is free.
	assign advance  = v_s1 && (!job_any || take_ready);
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entity_id_q  <= 16'd0;
			circuit_id_q <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENTITY_ID:  entity_id_q  <= cfg_data;
				CFG_CIRCUIT_ID: circuit_id_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	gprsns_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.proc_en   (advance),
		.mode      (mode_s1),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.job       (job),
		.job_any   (job_any)
	);

	gprsns_emitter u_emitter (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (advance && job_any),
		.job_in         (job),
		.entity_id      (entity_id_q),
		.circuit_id     (circuit_id_q),
		.take_ready     (take_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.result_byte    (result_byte),
		.last_result    (last_result),
		.pdu_outcome    (pdu_outcome),
		.link_alive     (link_alive),
		.rx_frame_total (rx_frame_total),
		.tx_frame_total (tx_frame_total),
		.rx_alive_total (rx_alive_total),
		.tx_alive_total (tx_alive_total)
	);

endmodule

`default_nettype wire

// ===== test/gprs_ns_pdu_handler_check.sv =====
// Result checker of the GPRS network-service PDU handler: predicts each result beat and compares.
module gprs_ns_pdu_handler_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  result_kind,
	input  logic [7:0]  result_byte,
	input  logic        last_result,
	input  logic [2:0]  pdu_outcome,
	input  logic        link_alive,
	input  logic [31:0] rx_frame_total,
	input  logic [31:0] tx_frame_total,
	input  logic [31:0] rx_alive_total,
	input  logic [31:0] tx_alive_total,
	output int          mismatch_total,
	output int          beats_awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	import gprsns_pkg::*;

	typedef enum logic [1:0] {
		SDU_NONE,
		SDU_RECEIVING,
		SDU_COMPLETE
	} sdu_t;

	typedef struct {
		kind_t       kind;
		logic [7:0]  value;
		logic        last;
		outcome_t    outcome;
		logic        alive;
		logic [31:0] rx_frames;
		logic [31:0] tx_frames;
		logic [31:0] rx_alives;
		logic [31:0] tx_alives;
	} beat_t;

	// Shadow of the parser, the connection and the counters.
	phase_t      parse_at;
	logic [7:0]  frame_type;
	logic [7:0]  value_left;
	logic        in_sdu;
	sdu_t        sdu_seen;
	logic        alive;
	logic [31:0] rx_frames_n;
	logic [31:0] tx_frames_n;
	logic [31:0] rx_alives_n;
	logic [31:0] tx_alives_n;
	logic [15:0] nsei;
	logic [15:0] nsvci;

	beat_t awaited_beats[$];

	task automatic report(input string what);
		mismatch_total++;
		$display("[%0t] pdu handler check: %s", $time, what);
	endtask

	task automatic push_beat(input kind_t kind, input logic [7:0] value, input logic last,
			input outcome_t outcome);
		beat_t b;
		b.kind = kind;
		b.value = value;
		b.last = last;
		b.outcome = outcome;
		b.alive = alive;
		b.rx_frames = rx_frames_n;
		b.tx_frames = tx_frames_n;
		b.rx_alives = rx_alives_n;
		b.tx_alives = tx_alives_n;
		awaited_beats.insert(awaited_beats.size(), b);
	endtask

	// One byte of the element walk inside a UNITDATA PDU.
	task automatic walk_element_byte(input logic [7:0] b);
		case (parse_at)
			PH_TAG: begin
				in_sdu = (b == TAG_SDU);
				parse_at = PH_LEN;
			end
			PH_LEN: begin
				value_left = b;
				if (in_sdu) begin
					sdu_seen = SDU_RECEIVING;
					if (b == 8'd0) begin
						sdu_seen = SDU_COMPLETE;
						parse_at = PH_IGNORE;
					end else begin
						parse_at = PH_VALUE;
					end
				end else begin
					parse_at = (b == 8'd0) ? PH_TAG : PH_VALUE;
				end
			end
			PH_VALUE: begin
				if (in_sdu)
					push_beat(KIND_PAYLOAD, b, 1'b0, OUT_NO_REPLY);
				value_left = value_left - 8'd1;
				if (value_left == 8'd0) begin
					if (in_sdu) begin
						sdu_seen = SDU_COMPLETE;
						parse_at = PH_IGNORE;
					end else begin
						parse_at = PH_TAG;
					end
				end
			end
			default: ;
		endcase
	endtask

	// End of a PDU: state update, reply bytes, then the status beat.
	task automatic close_pdu();
		logic [7:0] reply [0:8];
		int         reply_n;
		outcome_t   oc;
		reply_n = 0;
		oc = OUT_NO_REPLY;
		rx_frames_n++;
		case (frame_type)
			T_RESET: begin
				alive = 1'b0;
				reply[0] = T_RESET_ACK;
				reply[1] = TAG_CIRCUIT;
				reply[2] = ID_LEN;
				reply[3] = nsvci[15:8];
				reply[4] = nsvci[7:0];
				reply[5] = TAG_ENTITY;
				reply[6] = ID_LEN;
				reply[7] = nsei[15:8];
				reply[8] = nsei[7:0];
				reply_n = 9;
				oc = OUT_REPLIED;
			end
			T_RESET_ACK: begin
				alive = 1'b0;
				reply[0] = T_UNBLOCK;
				reply_n = 1;
				oc = OUT_REPLIED;
			end
			T_UNBLOCK: begin
				alive = 1'b1;
				reply[0] = T_UNBLOCK_ACK;
				reply_n = 1;
				oc = OUT_REPLIED;
			end
			T_UNBLOCK_ACK: begin
				alive = 1'b1;
				oc = OUT_NO_REPLY;
			end
			T_ALIVE: begin
				rx_alives_n++;
				tx_alives_n++;
				reply[0] = T_ALIVE_ACK;
				reply_n = 1;
				oc = OUT_REPLIED;
			end
			T_ALIVE_ACK: begin
				rx_alives_n++;
				oc = OUT_NO_REPLY;
			end
			T_UNITDATA: begin
				oc = (sdu_seen == SDU_COMPLETE) ? OUT_SDU_OK : OUT_SDU_BAD;
			end
			default: begin
				oc = OUT_UNKNOWN;
			end
		endcase
		if (reply_n != 0)
			tx_frames_n++;
		for (int i = 0; i < reply_n; i++)
			push_beat(KIND_REPLY, reply[i], 1'b0, OUT_NO_REPLY);
		push_beat(KIND_STATUS, 8'h00, 1'b1, oc);
		parse_at = PH_TYPE;
		value_left = 8'd0;
		in_sdu = 1'b0;
		sdu_seen = SDU_NONE;
	endtask

	task automatic parse_pdu_byte(input logic force_alive, input logic [7:0] b,
			input logic last);
		if (force_alive) begin
			alive = 1'b1;
		end else begin
			if (parse_at == PH_TYPE) begin
				frame_type = b;
				parse_at = (b == T_UNITDATA) ? PH_TAG : PH_IGNORE;
				value_left = 8'd0;
				in_sdu = 1'b0;
				sdu_seen = SDU_NONE;
			end else if (frame_type == T_UNITDATA) begin
				walk_element_byte(b);
			end
			if (last)
				close_pdu();
		end
	endtask

	task automatic compare_beat();
		beat_t e;
		if (awaited_beats.size() == 0) begin
			report("result beat with nothing awaited");
		end else begin
			e = awaited_beats.pop_front();
			if (result_kind !== e.kind)
				report($sformatf("result_kind %0d, want %0d", result_kind, e.kind));
			if (result_byte !== e.value)
				report($sformatf("result_byte %02h, want %02h", result_byte, e.value));
			if (last_result !== e.last)
				report($sformatf("last_result %0b, want %0b", last_result, e.last));
			if (pdu_outcome !== e.outcome)
				report($sformatf("pdu_outcome %0d, want %0d", pdu_outcome, e.outcome));
			if (link_alive !== e.alive)
				report($sformatf("link_alive %0b, want %0b", link_alive, e.alive));
			if (rx_frame_total !== e.rx_frames)
				report($sformatf("rx_frame_total %0d, want %0d", rx_frame_total, e.rx_frames));
			if (tx_frame_total !== e.tx_frames)
				report($sformatf("tx_frame_total %0d, want %0d", tx_frame_total, e.tx_frames));
			if (rx_alive_total !== e.rx_alives)
				report($sformatf("rx_alive_total %0d, want %0d", rx_alive_total, e.rx_alives));
			if (tx_alive_total !== e.tx_alives)
				report($sformatf("tx_alive_total %0d, want %0d", tx_alive_total, e.tx_alives));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_at = PH_TYPE;
			frame_type = 8'h00;
			value_left = 8'd0;
			in_sdu = 1'b0;
			sdu_seen = SDU_NONE;
			alive = 1'b0;
			rx_frames_n = '0;
			tx_frames_n = '0;
			rx_alives_n = '0;
			tx_alives_n = '0;
			nsei = '0;
			nsvci = '0;
			awaited_beats.delete();
			mismatch_total = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ENTITY_ID)
					nsei = cfg_data;
				else
					nsvci = cfg_data;
			end
			if (in_valid && in_ready)
				parse_pdu_byte(mode, data_byte, last_byte);
			if (out_valid && out_ready)
				compare_beat();
		end
		beats_awaited = awaited_beats.size();
	end

endmodule

// ===== test/gprs_ns_pdu_handler_test.sv =====
// Testbench top of the GPRS network-service PDU handler: stimulus, back pressure and verdict.
module gprs_ns_pdu_handler_test;
	timeunit 1ns;
	timeprecision 1ps;

	import gprsns_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int RESET_CYCLES = 11;
	// A beat enters the input register and is then parsed, so the settle wait covers
	// a force-alive beat that is still in flight.
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 72;
	localparam longint RUN_LIMIT = 64'd10_000_000;

	localparam logic MODE_PDU = 1'b0;
	localparam logic MODE_FORCE_ALIVE = 1'b1;

	typedef logic [7:0] pdu_t[$];

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  result_kind;
	logic [7:0]  result_byte;
	logic        last_result;
	logic [2:0]  pdu_outcome;
	logic        link_alive;
	logic [31:0] rx_frame_total;
	logic [31:0] tx_frame_total;
	logic [31:0] rx_alive_total;
	logic [31:0] tx_alive_total;
	int          mismatch_total;
	int          beats_awaited;

	// Pacing controls. A steady side neither idles nor stalls; the flags flip now
	// and then so that long gap-free stretches mix with heavily idled ones.
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit rx_hold = 1'b0;
	bit force_mix = 1'b0;
	int items_sent = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	gprs_ns_pdu_handler DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.result_byte    (result_byte),
		.last_result    (last_result),
		.pdu_outcome    (pdu_outcome),
		.link_alive     (link_alive),
		.rx_frame_total (rx_frame_total),
		.tx_frame_total (tx_frame_total),
		.rx_alive_total (rx_alive_total),
		.tx_alive_total (tx_alive_total)
	);

	gprs_ns_pdu_handler_check checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.result_byte    (result_byte),
		.last_result    (last_result),
		.pdu_outcome    (pdu_outcome),
		.link_alive     (link_alive),
		.rx_frame_total (rx_frame_total),
		.tx_frame_total (tx_frame_total),
		.rx_alive_total (rx_alive_total),
		.tx_alive_total (tx_alive_total),
		.mismatch_total (mismatch_total),
		.beats_awaited  (beats_awaited)
	);

	// Offers one input beat after a random idle gap and returns at the falling
	// edge after it is taken. The caller must drive the next value at that same
	// edge, otherwise the held beat would be taken a second time.
	task automatic offer_byte(input logic m, input logic [7:0] b, input logic l);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		mode = m;
		data_byte = b;
		last_byte = l;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		@(negedge clk);
	endtask

	// Sends a PDU, flagging its final byte. In the random part force-alive beats
	// with random data and last bits are slipped in between PDU bytes; they must
	// not disturb the PDU in progress.
	task automatic offer_pdu(input pdu_t pdu);
		if ($urandom_range(0, 7) == 0)
			tx_steady = !tx_steady;
		for (int i = 0; i < pdu.size(); i++) begin
			if (force_mix && $urandom_range(0, 15) == 0)
				offer_byte(MODE_FORCE_ALIVE, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			offer_byte(MODE_PDU, pdu[i], i == pdu.size() - 1);
		end
	endtask

	// Adds one byte at the end of a PDU under construction.
	function automatic void append_byte(ref pdu_t pdu, input logic [7:0] b);
		pdu.insert(pdu.size(), b);
	endfunction

	// A UNITDATA PDU: a few foreign elements, the SDU element, some trailing
	// bytes, and now and then a cut at a random point to truncate the walk.
	function automatic pdu_t unitdata_pdu();
		pdu_t       pdu;
		logic [7:0] tag;
		int         elem_len;
		int         sdu_len;
		int         cut;
		append_byte(pdu, T_UNITDATA);
		repeat ($urandom_range(0, 2)) begin
			tag = 8'($urandom_range(0, 255));
			if (tag == TAG_SDU)
				tag = TAG_CIRCUIT;
			elem_len = $urandom_range(0, 4);
			append_byte(pdu, tag);
			append_byte(pdu, 8'(elem_len));
			repeat (elem_len) append_byte(pdu, 8'($urandom_range(0, 255)));
		end
		// Mostly short SDUs; a rare long one reaches the top of the length range.
		if ($urandom_range(0, 39) == 0)
			sdu_len = ($urandom_range(0, 1) == 1) ? 255 : $urandom_range(100, 254);
		else
			sdu_len = $urandom_range(0, 8);
		append_byte(pdu, TAG_SDU);
		append_byte(pdu, 8'(sdu_len));
		repeat (sdu_len) append_byte(pdu, 8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 2)) append_byte(pdu, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 4) == 0) begin
			cut = $urandom_range(1, pdu.size() - 1);
			pdu = pdu[0:cut - 1];
		end
		return pdu;
	endfunction

	// A signaling PDU whose type produces a reply or a state change.
	function automatic pdu_t control_pdu();
		pdu_t       pdu;
		logic [7:0] codes [0:5];
		codes = '{T_RESET, T_RESET_ACK, T_UNBLOCK, T_UNBLOCK_ACK, T_ALIVE, T_ALIVE_ACK};
		append_byte(pdu, codes[$urandom_range(0, 5)]);
		repeat ($urandom_range(0, 2)) append_byte(pdu, 8'($urandom_range(0, 255)));
		return pdu;
	endfunction

	// Random bytes, so mostly unknown types and every bit of data_byte.
	function automatic pdu_t noise_pdu();
		pdu_t pdu;
		repeat ($urandom_range(1, 6)) append_byte(pdu, 8'($urandom_range(0, 255)));
		return pdu;
	endfunction

	// Stops offering and waits until every awaited result beat has been taken,
	// then lets a possible result-less beat leave the pipeline.
	task automatic drain();
		in_valid = 1'b0;
		while (beats_awaited != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes both identifiers on consecutive cycles; only called while idle.
	task automatic program_ids(input logic [15:0] ei, input logic [15:0] ci);
		cfg_we = 1'b1;
		cfg_index = CFG_ENTITY_ID;
		cfg_data = ei;
		@(negedge clk);
		cfg_index = CFG_CIRCUIT_ID;
		cfg_data = ci;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic run_random(input int count);
		int target;
		int pick;
		target = items_sent + count;
		while (items_sent < target) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				offer_pdu(unitdata_pdu());
			else if (pick < 8)
				offer_pdu(control_pdu());
			else
				offer_pdu(noise_pdu());
		end
	endtask

	// Result side: random stalls before each beat, and on request one long
	// hold-off during which the sender keeps offering so the block backs up.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold = 1'b0;
			end
			if ($urandom_range(0, 31) == 0)
				rx_steady = !rx_steady;
			stall = rx_steady ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		cfg_we = 1'b0;
		cfg_index = CFG_ENTITY_ID;
		cfg_data = 16'h0000;
		in_valid = 1'b0;
		mode = MODE_PDU;
		data_byte = 8'h00;
		last_byte = 1'b0;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: every PDU type (with its reply where it gives one), an unknown type, and
		// the UNITDATA walk cases (delivered, empty SDU, truncated value, lone
		// trailing tag, type byte only), plus a force-alive beat.
		program_ids(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		offer_pdu('{T_RESET});
		offer_pdu('{T_ALIVE});
		offer_pdu('{T_ALIVE_ACK});
		offer_pdu('{T_RESET_ACK});
		offer_pdu('{T_UNBLOCK});
		offer_pdu('{T_UNBLOCK_ACK});
		offer_pdu('{8'hFF});
		offer_pdu('{T_UNITDATA, TAG_SDU, 8'h02, 8'h00, 8'hFF});
		offer_pdu('{T_UNITDATA, TAG_SDU, 8'h00});
		offer_pdu('{T_UNITDATA, TAG_SDU, 8'h05, 8'h11});
		offer_pdu('{T_UNITDATA, TAG_CIRCUIT});
		offer_byte(MODE_FORCE_ALIVE, 8'hFF, 1'b1);
		offer_pdu('{T_UNITDATA});

		// Random part in phases with different identifiers, the extremes first.
		// Each phase change lets the sender wait until all results are out.
		force_mix = 1'b1;
		drain();
		program_ids(16'h0000, 16'hFFFF);
		run_random(ITEMS_PER_PHASE);

		drain();
		program_ids(16'hFFFF, 16'h0000);
		rx_hold = 1'b1;
		run_random(ITEMS_PER_PHASE);

		drain();
		program_ids(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		run_random(ITEMS_PER_PHASE);

		drain();
		program_ids(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		run_random(ITEMS_PER_PHASE);

		drain();
		if (mismatch_total == 0 && beats_awaited == 0) begin
			$display("gprs_ns_pdu_handler: match");
		end else begin
			$display("gprs_ns_pdu_handler: mismatch");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(RUN_LIMIT);
		$display("gprs_ns_pdu_handler: mismatch");
		$finish;
	end

endmodule
